FILE: sv/lpfr_pkg.sv
// Shared types, codes and constants for the length-prefixed frame receiver.
// No dependencies; every other file of the block but lpfr_fifo uses this package.
`timescale 1ns / 1ps

package lpfr_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 512;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 2'd1;

  localparam logic [9:0]  MAX_FRAME_LEN_RST = 10'd512;
  localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd10000;

  localparam logic [1:0] OP_DATA       = 2'd0;
  localparam logic [1:0] OP_TICK       = 2'd1;
  localparam logic [1:0] OP_CONNECT    = 2'd2;
  localparam logic [1:0] OP_DISCONNECT = 2'd3;

  localparam logic [1:0] ST_BYTE    = 2'd0;
  localparam logic [1:0] ST_BADLEN  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_ABORT   = 2'd3;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_TICK,
    KIND_CONNECT,
    KIND_DISCONNECT
  } kind_t;

  typedef enum logic [1:0] {
    PH_CLOSED,
    PH_HIGH,
    PH_LOW,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] payload_byte;
    logic       last_byte;
    logic [9:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [9:0]  max_frame_len;
    logic [15:0] idle_timeout_ticks;
  } cfg_t;

endpackage

FILE: sv/lpfr_fifo.sv
// Small register queue with a push/full and pop/empty handshake.
// Generic payload width and depth; uses no package items.
`timescale 1ns / 1ps

module lpfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

FILE: sv/lpfr_front.sv
// Front end: accepts input transactions, decodes the opcode into an item kind
// and queues the item. Depends on lpfr_pkg and lpfr_fifo.
`timescale 1ns / 1ps

module lpfr_front #(
  parameter int QUEUE_DEPTH = lpfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        data_byte_i,
  input  logic              pop_i,
  output lpfr_pkg::item_t   item_o,
  output logic              empty_o
);

  lpfr_pkg::item_t item_in;
  logic [$bits(lpfr_pkg::item_t)-1:0] q_out;

  always_comb begin
    item_in.data_byte = data_byte_i;
    unique case (opcode_i)
      lpfr_pkg::OP_DATA:       item_in.kind = lpfr_pkg::KIND_DATA;
      lpfr_pkg::OP_TICK:       item_in.kind = lpfr_pkg::KIND_TICK;
      lpfr_pkg::OP_CONNECT:    item_in.kind = lpfr_pkg::KIND_CONNECT;
      lpfr_pkg::OP_DISCONNECT: item_in.kind = lpfr_pkg::KIND_DISCONNECT;
      default:                 item_in.kind = lpfr_pkg::KIND_DATA;
    endcase
  end

  lpfr_fifo #(
    .WIDTH ($bits(lpfr_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (full),
    .pop_i   (pop_i),
    .data_o  (q_out),
    .empty_o (empty_o)
  );

  assign item_o = lpfr_pkg::item_t'(q_out);

endmodule

FILE: sv/lpfr_back.sv
// Back end: link and framing state machine with the idle counter.
// Takes one queued item per cycle unless the result queue is full; produces at most one result. Depends on lpfr_pkg.
`timescale 1ns / 1ps

module lpfr_back #(
  parameter int MAX_FRAME_BYTES = lpfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lpfr_pkg::cfg_t     cfg_i,
  input  lpfr_pkg::item_t    item_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output lpfr_pkg::result_t  res_o
);

  localparam int LEN_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES + 1) : 1;

  lpfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       len_high_r, len_high_nxt;
  logic [LEN_W-1:0] exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [15:0]      idle_r, idle_nxt;

  logic [15:0]      len_word;
  logic             bad_len;
  logic [15:0]      idle_inc;
  logic [LEN_W-1:0] rcv_inc;
  logic [9:0]       cur_len;

  assign item_take_o = item_valid_i && !res_full_i;
  assign len_word    = {len_high_r, item_i.data_byte};
  assign bad_len     = (len_word == 16'd0) || (len_word > {6'd0, cfg_i.max_frame_len})
                       || (len_word > 16'(MAX_FRAME_BYTES));
  assign idle_inc    = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign rcv_inc     = rcv_cnt_r + 1'b1;
  assign cur_len     = (phase_r == lpfr_pkg::PH_PAYLOAD) ? 10'(exp_len_r) : 10'd0;

  always_comb begin
    phase_nxt          = phase_r;
    len_high_nxt       = len_high_r;
    exp_len_nxt        = exp_len_r;
    rcv_cnt_nxt        = rcv_cnt_r;
    idle_nxt           = idle_r;
    res_push_o         = 1'b0;
    res_o.status       = lpfr_pkg::ST_BYTE;
    res_o.payload_byte = 8'd0;
    res_o.last_byte    = 1'b0;
    res_o.frame_length = 10'd0;
    if (item_take_o) begin
      unique case (phase_r)
        lpfr_pkg::PH_CLOSED: begin
          if (item_i.kind == lpfr_pkg::KIND_CONNECT) begin
            phase_nxt    = lpfr_pkg::PH_HIGH;
            len_high_nxt = 8'd0;
            exp_len_nxt  = '0;
            rcv_cnt_nxt  = '0;
            idle_nxt     = 16'd0;
          end
        end
        lpfr_pkg::PH_HIGH, lpfr_pkg::PH_LOW, lpfr_pkg::PH_PAYLOAD: begin
          case (item_i.kind)
            lpfr_pkg::KIND_CONNECT: begin
            end
            lpfr_pkg::KIND_DISCONNECT: begin
              phase_nxt          = lpfr_pkg::PH_CLOSED;
              len_high_nxt       = 8'd0;
              exp_len_nxt        = '0;
              rcv_cnt_nxt        = '0;
              idle_nxt           = 16'd0;
              res_push_o         = (phase_r != lpfr_pkg::PH_HIGH);
              res_o.status       = lpfr_pkg::ST_ABORT;
              res_o.frame_length = cur_len;
            end
            lpfr_pkg::KIND_TICK: begin
              idle_nxt = idle_inc;
              if (idle_inc > cfg_i.idle_timeout_ticks) begin
                phase_nxt          = lpfr_pkg::PH_CLOSED;
                len_high_nxt       = 8'd0;
                exp_len_nxt        = '0;
                rcv_cnt_nxt        = '0;
                idle_nxt           = 16'd0;
                res_push_o         = 1'b1;
                res_o.status       = lpfr_pkg::ST_TIMEOUT;
                res_o.frame_length = cur_len;
              end
            end
            default: begin
              idle_nxt = 16'd0;
              if (phase_r == lpfr_pkg::PH_HIGH) begin
                len_high_nxt = item_i.data_byte;
                phase_nxt    = lpfr_pkg::PH_LOW;
              end else if (phase_r == lpfr_pkg::PH_LOW) begin
                if (bad_len) begin
                  phase_nxt    = lpfr_pkg::PH_CLOSED;
                  len_high_nxt = 8'd0;
                  exp_len_nxt  = '0;
                  rcv_cnt_nxt  = '0;
                  res_push_o   = 1'b1;
                  res_o.status = lpfr_pkg::ST_BADLEN;
                end else begin
                  exp_len_nxt = LEN_W'(len_word);
                  rcv_cnt_nxt = '0;
                  phase_nxt   = lpfr_pkg::PH_PAYLOAD;
                end
              end else begin
                res_push_o         = 1'b1;
                res_o.status       = lpfr_pkg::ST_BYTE;
                res_o.payload_byte = item_i.data_byte;
                res_o.frame_length = 10'(exp_len_r);
                rcv_cnt_nxt        = rcv_inc;
                if (rcv_inc >= exp_len_r) begin
                  res_o.last_byte = 1'b1;
                  phase_nxt       = lpfr_pkg::PH_HIGH;
                  len_high_nxt    = 8'd0;
                  exp_len_nxt     = '0;
                  rcv_cnt_nxt     = '0;
                end
              end
            end
          endcase
        end
        default: begin
          phase_nxt = lpfr_pkg::PH_CLOSED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lpfr_pkg::PH_CLOSED;
      len_high_r <= 8'd0;
      exp_len_r  <= '0;
      rcv_cnt_r  <= '0;
      idle_r     <= 16'd0;
    end else begin
      phase_r    <= phase_nxt;
      len_high_r <= len_high_nxt;
      exp_len_r  <= exp_len_nxt;
      rcv_cnt_r  <= rcv_cnt_nxt;
      idle_r     <= idle_nxt;
    end
  end

endmodule

FILE: sv/length_prefixed_frame_receiver_top.sv
// Top level of the length-prefixed frame receiver: configuration registers,
// front end, back end and result queue. Depends on lpfr_pkg, lpfr_front,
// lpfr_back and lpfr_fifo.
//
//   Channel   Handshake            Payload
//   input     push / full          in_opcode, in_data_byte
//   result    empty / pop          out_status, out_payload_byte, out_last_byte,
//                                  out_frame_length
//   config    cfg_wr_en            cfg_index, cfg_wdata
//
// One item per cycle is sustained while the result queue is not full: the back end retires
// one queued item each cycle. Results reach the result ports through the registered result queue.
// Reset clears both queues, closes the link and restores the register reset values.
// The front queue raises full when it holds QUEUE_DEPTH items; the back end
// waits while the result queue is full.
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_top #(
  parameter int MAX_FRAME_BYTES = lpfr_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = lpfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_opcode,
  input  logic [7:0]                    in_data_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_payload_byte,
  output logic                          out_last_byte,
  output logic [9:0]                    out_frame_length,
  input  logic                          cfg_wr_en,
  input  logic [lpfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lpfr_pkg::cfg_t    cfg_r;
  lpfr_pkg::item_t   item;
  lpfr_pkg::result_t res_in;
  lpfr_pkg::result_t res_out;
  logic [$bits(lpfr_pkg::result_t)-1:0] res_q_out;
  logic item_empty, item_take, res_full, res_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_len      <= lpfr_pkg::MAX_FRAME_LEN_RST;
      cfg_r.idle_timeout_ticks <= lpfr_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == lpfr_pkg::CFG_MAX_FRAME_LEN) begin
        cfg_r.max_frame_len <= cfg_wdata[9:0];
      end else if (cfg_index == lpfr_pkg::CFG_IDLE_TIMEOUT) begin
        cfg_r.idle_timeout_ticks <= cfg_wdata[15:0];
      end
    end
  end

  lpfr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .opcode_i    (in_opcode),
    .data_byte_i (in_data_byte),
    .pop_i       (item_take),
    .item_o      (item),
    .empty_o     (item_empty)
  );

  lpfr_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg_r),
    .item_i       (item),
    .item_valid_i (!item_empty),
    .item_take_o  (item_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  lpfr_fifo #(
    .WIDTH ($bits(lpfr_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_q_out),
    .empty_o (empty)
  );

  assign res_out          = lpfr_pkg::result_t'(res_q_out);
  assign out_status       = res_out.status;
  assign out_payload_byte = res_out.payload_byte;
  assign out_last_byte    = res_out.last_byte;
  assign out_frame_length = res_out.frame_length;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for length_prefixed_frame_receiver_top: a table of directed
// transactions, then random framed traffic under several register settings.
// Depends on lpfr_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import lpfr_pkg::*;

  localparam int FRAME_CAP = MAX_FRAME_BYTES_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byt;
    logic       typed;
    logic       has_res;
    result_t    res;
  } link_item_t;

  localparam result_t NO_RESULT = '0;

  localparam link_item_t DIRECTED_ITEMS [25] = '{
    '{OP_DATA,       8'hFF, 1'b1, 1'b0, NO_RESULT},
    '{OP_TICK,       8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DISCONNECT, 8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_CONNECT,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_CONNECT,    8'hFF, 1'b1, 1'b0, NO_RESULT},
    '{OP_DISCONNECT, 8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_CONNECT,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h00, 1'b1, 1'b1, result_t'{ST_BADLEN, 8'h00, 1'b0, 10'd0}},
    '{OP_CONNECT,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h02, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h01, 1'b1, 1'b1, result_t'{ST_BADLEN, 8'h00, 1'b0, 10'd0}},
    '{OP_CONNECT,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h01, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'hFF, 1'b1, 1'b1, result_t'{ST_BYTE, 8'hFF, 1'b1, 10'd1}},
    '{OP_DATA,       8'h02, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h00, 1'b1, 1'b1, result_t'{ST_BYTE, 8'h00, 1'b0, 10'd512}},
    '{OP_DATA,       8'hA5, 1'b0, 1'b0, NO_RESULT},
    '{OP_TICK,       8'h00, 1'b0, 1'b0, NO_RESULT},
    '{OP_DISCONNECT, 8'h00, 1'b1, 1'b1, result_t'{ST_ABORT, 8'h00, 1'b0, 10'd512}},
    '{OP_CONNECT,    8'h00, 1'b1, 1'b0, NO_RESULT},
    '{OP_DATA,       8'h80, 1'b1, 1'b0, NO_RESULT},
    '{OP_DISCONNECT, 8'h00, 1'b1, 1'b1, result_t'{ST_ABORT, 8'h00, 1'b0, 10'd0}}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [1:0]            in_opcode = '0;
  logic [7:0]            in_data_byte = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [1:0]            out_status;
  logic [7:0]            out_payload_byte;
  logic                  out_last_byte;
  logic [9:0]            out_frame_length;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  phase_t      frame_phase;
  logic [7:0]  len_hi;
  logic [9:0]  frame_len;
  logic [9:0]  rx_count;
  logic [15:0] idle_ticks;
  logic [9:0]  max_len_reg;
  logic [15:0] timeout_reg;

  link_item_t link_items [$];
  result_t    awaited_results [$];
  link_item_t in_flight_item;
  result_t    predicted;
  result_t    seen;
  bit         got;
  bit         no_gaps = 1'b0;
  bit         long_hold_req = 1'b0;
  bit         take;
  int         burst_left = 0;
  int         gap_left = 0;
  int         hold_left = 0;
  int         rx_mode = 0;
  int         rx_left = 0;
  int         items_taken = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         settings_used = 0;
  int         cycle_count = 0;
  int         status_seen [4] = '{0, 0, 0, 0};

  length_prefixed_frame_receiver_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_payload_byte (out_payload_byte),
    .out_last_byte    (out_last_byte),
    .out_frame_length (out_frame_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void drop_link();
    frame_phase = PH_CLOSED;
    idle_ticks = '0;
    len_hi = '0;
    frame_len = '0;
    rx_count = '0;
  endfunction

  function automatic bit deframe_step(input logic [1:0] op, input logic [7:0] b,
                                      output result_t r);
    logic [15:0] len16;
    logic [9:0]  lim;
    bit          emits;
    r = '0;
    emits = 1'b0;
    if (frame_phase == PH_CLOSED) begin
      if (op == OP_CONNECT) begin
        drop_link();
        frame_phase = PH_HIGH;
      end
    end else begin
      case (op)
        OP_DISCONNECT: begin
          emits = (frame_phase != PH_HIGH);
          r.status = ST_ABORT;
          r.frame_length = (frame_phase == PH_PAYLOAD) ? frame_len : 10'd0;
          drop_link();
        end
        OP_TICK: begin
          if (idle_ticks != 16'hFFFF) idle_ticks++;
          if (idle_ticks > timeout_reg) begin
            emits = 1'b1;
            r.status = ST_TIMEOUT;
            r.frame_length = (frame_phase == PH_PAYLOAD) ? frame_len : 10'd0;
            drop_link();
          end
        end
        OP_DATA: begin
          idle_ticks = '0;
          case (frame_phase)
            PH_HIGH: begin
              len_hi = b;
              frame_phase = PH_LOW;
            end
            PH_LOW: begin
              len16 = {len_hi, b};
              lim = (max_len_reg > FRAME_CAP) ? 10'(FRAME_CAP) : max_len_reg;
              if (len16 == 16'd0 || len16 > lim) begin
                emits = 1'b1;
                r.status = ST_BADLEN;
                drop_link();
              end else begin
                frame_len = len16[9:0];
                rx_count = '0;
                frame_phase = PH_PAYLOAD;
              end
            end
            default: begin
              rx_count++;
              emits = 1'b1;
              r.status = ST_BYTE;
              r.payload_byte = b;
              r.frame_length = frame_len;
              r.last_byte = (rx_count >= frame_len);
              if (r.last_byte) begin
                len_hi = '0;
                frame_len = '0;
                rx_count = '0;
                frame_phase = PH_HIGH;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
    return emits;
  endfunction

  function automatic void queue_item(input logic [1:0] op, input logic [7:0] b);
    link_item_t it;
    it = '0;
    it.op = op;
    it.byt = b;
    link_items.push_back(it);
  endfunction

  function automatic void idle_gap();
    int n;
    if (timeout_reg < 16'd64 && $urandom_range(0, 9) == 0) n = timeout_reg + 1;
    else n = $urandom_range(0, 2);
    repeat (n) queue_item(OP_TICK, 8'($urandom));
    if (n > timeout_reg) queue_item(OP_CONNECT, 8'($urandom));
  endfunction

  function automatic void gen_traffic(input int n_frames);
    int lim;
    int cap;
    int len;
    int cut;
    lim = (max_len_reg > FRAME_CAP) ? FRAME_CAP : int'(max_len_reg);
    cap = (lim == 0) ? 3 : ((lim < 12) ? lim : 12);
    queue_item(OP_CONNECT, 8'($urandom));
    for (int f = 0; f < n_frames; f++) begin
      if ($urandom_range(0, 15) == 0) queue_item(2'($urandom), 8'($urandom));
      case ($urandom_range(0, 19))
        0: len = 0;
        1: len = lim + 1;
        2: len = $urandom_range(0, 65535);
        3: len = (lim == 0) ? 1 : lim;
        default: len = $urandom_range(1, cap);
      endcase
      idle_gap();
      queue_item(OP_DATA, len[15:8]);
      idle_gap();
      queue_item(OP_DATA, len[7:0]);
      if (len == 0 || len > lim) begin
        queue_item(OP_CONNECT, 8'($urandom));
      end else begin
        cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++) begin
          if ($urandom_range(0, 7) == 0) idle_gap();
          queue_item(OP_DATA, 8'($urandom));
        end
        if (cut < len) begin
          queue_item(OP_DISCONNECT, 8'($urandom));
          queue_item(OP_CONNECT, 8'($urandom));
        end
      end
    end
    if ($urandom_range(0, 1) == 0) queue_item(OP_DISCONNECT, 8'($urandom));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MAX_FRAME_LEN) max_len_reg = val[9:0];
    else if (idx == CFG_IDLE_TIMEOUT) timeout_reg = val;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (link_items.size() != 0 || push || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settings_used++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        items_taken++;
        got = deframe_step(in_flight_item.op, in_flight_item.byt, predicted);
        if (in_flight_item.typed) begin
          if (in_flight_item.has_res) awaited_results.push_back(in_flight_item.res);
        end else if (got) begin
          awaited_results.push_back(predicted);
        end
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (link_items.size() != 0) begin
          in_flight_item = link_items.pop_front();
          push <= 1'b1;
          in_opcode <= in_flight_item.op;
          in_data_byte <= in_flight_item.byt;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: alternates between free-running, random and mostly stalled stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (long_hold_req) begin
        hold_left = HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
          0: take = 1'b1;
          1: take = $urandom_range(0, 1);
          default: take = ($urandom_range(0, 3) == 0);
        endcase
      end
      pop <= take;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      results_seen++;
      status_seen[out_status]++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_status);
        mismatches++;
      end else begin
        seen = awaited_results.pop_front();
        if (out_status !== seen.status) begin
          $error("status: expected %0d, actual %0d", seen.status, out_status);
          mismatches++;
        end
        if (out_payload_byte !== seen.payload_byte) begin
          $error("payload_byte: expected 0x%02h, actual 0x%02h",
                 seen.payload_byte, out_payload_byte);
          mismatches++;
        end
        if (out_last_byte !== seen.last_byte) begin
          $error("last_byte: expected %0d, actual %0d", seen.last_byte, out_last_byte);
          mismatches++;
        end
        if (out_frame_length !== seen.frame_length) begin
          $error("frame_length: expected %0d, actual %0d",
                 seen.frame_length, out_frame_length);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    max_len_reg = MAX_FRAME_LEN_RST;
    timeout_reg = IDLE_TIMEOUT_RST;
    drop_link();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ITEMS[i]) link_items.push_back(DIRECTED_ITEMS[i]);
    drain();

    write_reg(CFG_MAX_FRAME_LEN, 16'hFC05);
    write_reg(CFG_IDLE_TIMEOUT, 16'd3);
    gen_traffic(12);
    drain();

    write_reg(CFG_MAX_FRAME_LEN, 16'hFC00);
    write_reg(CFG_IDLE_TIMEOUT, 16'h0000);
    gen_traffic(6);
    drain();

    // At the largest register values the length limit falls back to the frame cap.
    write_reg(CFG_MAX_FRAME_LEN, 16'hFFFF);
    write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
    write_reg(CFG_SPARE_A, 16'h1234);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    no_gaps = 1'b1;
    queue_item(OP_CONNECT, 8'h00);
    repeat (3) queue_item(OP_TICK, 8'($urandom));
    queue_item(OP_DATA, 8'h02);
    queue_item(OP_DATA, 8'h00);
    repeat (6) queue_item(OP_DATA, 8'($urandom));
    queue_item(OP_DISCONNECT, 8'h00);
    queue_item(OP_CONNECT, 8'h00);
    queue_item(OP_DATA, 8'h02);
    queue_item(OP_DATA, 8'h01);
    drain();
    no_gaps = 1'b0;

    write_reg(CFG_MAX_FRAME_LEN, 16'd1);
    write_reg(CFG_IDLE_TIMEOUT, 16'd1);
    gen_traffic(10);
    drain();

    write_reg(CFG_MAX_FRAME_LEN, 16'd16);
    write_reg(CFG_IDLE_TIMEOUT, 16'd40);
    @(negedge clk);
    long_hold_req = 1'b1;
    gen_traffic(8);
    drain();

    $display("Covered %0d input and %0d result transactions over %0d register settings.",
             items_taken, results_seen, settings_used);
    $display("Results: %0d payload bytes, %0d bad lengths, %0d timeouts, %0d aborts.",
             status_seen[ST_BYTE], status_seen[ST_BADLEN], status_seen[ST_TIMEOUT],
             status_seen[ST_ABORT]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lpfr_pkg.sv
sv/lpfr_fifo.sv
sv/lpfr_front.sv
sv/lpfr_back.sv
sv/length_prefixed_frame_receiver_top.sv
dv/testbench.sv
